[hw/rtl/hbpq_pkg.sv]
// shared types and codes for the binary heap priority queue
`default_nettype none
package hbpq_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 11;
    localparam int STAT_W  = 2;

    // request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // read port a address select
    localparam logic [1:0] RD_LEFT   = 2'd0;
    localparam logic [1:0] RD_PARENT = 2'd1;
    localparam logic [1:0] RD_LAST   = 2'd2;

    typedef struct packed {
        logic       ins_start;
        logic       del_start;
        logic       rej_full;
        logic       rej_empty;
        logic       load_cur;
        logic       step_up;
        logic       step_dn;
        logic       wr_cur;
        logic [1:0] rd_sel;
        logic       load_out;
    } hbpq_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic count_zero;
        logic child_none;
        logic up_move;
        logic dn_move;
    } hbpq_sts_t;

    // true when x belongs strictly above y; order 0 max-heap, 1 min-heap
    function automatic logic ahead(input logic order, input logic signed [DATA_W-1:0] x,
                                   input logic signed [DATA_W-1:0] y);
        ahead = order ? (x < y) : (x > y);
    endfunction

endpackage
`default_nettype wire

[hw/rtl/binary_heap_priority_queue.sv]
// binary heap priority queue: top level
// an insert climbs and a delete descends the heap one level per pass of the
// read-then-compare loop on the single heap memory; one request is worked at a time
// and the next is taken once its result is loaded
// the result register lets the next request enter while a result waits
// reset clears the count and selects max-heap order; heap entries are not cleared
`default_nettype none
module binary_heap_priority_queue #(
    parameter int HEAP_DEPTH = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,   // heap_order
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,     // value
    input  wire logic        s_tuser,     // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // removed_value[31:0], root_value[63:32], root_valid[64], element_count[75:65],
    // status[77:76], zero pad[79:78]
    output logic [79:0]      m_tdata
);
    import hbpq_pkg::*;

    hbpq_cmd_t                cmd;
    hbpq_sts_t                sts;
    logic signed [DATA_W-1:0] out_removed, out_root;
    logic                     out_root_valid;
    logic [COUNT_W-1:0]       out_count;
    logic [STAT_W-1:0]        out_status;

    hbpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_req    (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hbpq_dp #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_value        (s_tdata),
        .cmd            (cmd),
        .sts            (sts),
        .out_removed    (out_removed),
        .out_root       (out_root),
        .out_root_valid (out_root_valid),
        .out_count      (out_count),
        .out_status     (out_status)
    );

    assign m_tdata = {2'b00, out_status, out_count, out_root_valid, out_root, out_removed};

endmodule
`default_nettype wire

[hw/rtl/hbpq_ctrl.sv]
// request sequencer for the heap engine
`default_nettype none
module hbpq_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic               s_req,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire hbpq_pkg::hbpq_sts_t sts,
    output hbpq_pkg::hbpq_cmd_t     cmd
);
    import hbpq_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_CHK  = 3'd1;
    localparam logic [2:0] S_UP_CMP  = 3'd2;
    localparam logic [2:0] S_DN_LAST = 3'd3;
    localparam logic [2:0] S_DN_LOAD = 3'd4;
    localparam logic [2:0] S_DN_CHK  = 3'd5;
    localparam logic [2:0] S_DN_CMP  = 3'd6;
    localparam logic [2:0] S_RESP    = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_LEFT;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_req == REQ_INSERT) begin
                        if (sts.full) begin
                            cmd.rej_full = 1'b1;
                            state_next   = S_RESP;
                        end else begin
                            cmd.ins_start = 1'b1;
                            state_next    = S_UP_CHK;
                        end
                    end else begin
                        if (sts.empty) begin
                            cmd.rej_empty = 1'b1;
                            state_next    = S_RESP;
                        end else begin
                            cmd.del_start = 1'b1;
                            state_next    = S_DN_LAST;
                        end
                    end
                end
            end
            S_UP_CHK: begin
                cmd.rd_sel = RD_PARENT;
                if (sts.pos_zero) begin
                    cmd.wr_cur = 1'b1;
                    state_next = S_RESP;
                end else begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (sts.up_move) begin
                    cmd.step_up = 1'b1;
                    state_next  = S_UP_CHK;
                end else begin
                    cmd.wr_cur = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_DN_LAST: begin
                // fetch the last entry, nothing to sift if the heap just emptied
                cmd.rd_sel = RD_LAST;
                state_next = sts.count_zero ? S_RESP : S_DN_LOAD;
            end
            S_DN_LOAD: begin
                cmd.load_cur = 1'b1;
                state_next   = S_DN_CHK;
            end
            S_DN_CHK: begin
                cmd.rd_sel = RD_LEFT;
                if (sts.child_none) begin
                    cmd.wr_cur = 1'b1;
                    state_next = S_RESP;
                end else begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (sts.dn_move) begin
                    cmd.step_dn = 1'b1;
                    state_next  = S_DN_CHK;
                end else begin
                    cmd.wr_cur = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/hbpq_dp.sv]
// heap storage, index arithmetic, compares and result registers
`default_nettype none
module hbpq_dp #(
    parameter int HEAP_DEPTH = 1024
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_wdata,
    input  wire logic signed [hbpq_pkg::DATA_W-1:0]  s_value,
    input  wire hbpq_pkg::hbpq_cmd_t                 cmd,
    output hbpq_pkg::hbpq_sts_t                      sts,
    output logic signed [hbpq_pkg::DATA_W-1:0]       out_removed,
    output logic signed [hbpq_pkg::DATA_W-1:0]       out_root,
    output logic                                     out_root_valid,
    output logic [hbpq_pkg::COUNT_W-1:0]             out_count,
    output logic [hbpq_pkg::STAT_W-1:0]              out_status
);
    import hbpq_pkg::*;

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int IW = AW + 2;

    logic signed [DATA_W-1:0] mem [HEAP_DEPTH];

    logic                     order_reg;
    logic [CW-1:0]            count_reg;
    logic [AW-1:0]            pos_reg;
    logic signed [DATA_W-1:0] cur_reg;
    logic signed [DATA_W-1:0] root_reg;
    logic signed [DATA_W-1:0] removed_reg;
    logic [STAT_W-1:0]        status_reg;
    logic signed [DATA_W-1:0] rd_a_reg, rd_b_reg;

    logic [IW-1:0]            pos_ext, count_ext, parent_idx, left_idx, right_idx;
    logic [AW-1:0]            rd_addr_a;
    logic                     pick_left;
    logic signed [DATA_W-1:0] pick_val;
    logic [AW-1:0]            pick_idx;
    logic                     wr_en;
    logic signed [DATA_W-1:0] wr_data;
    logic [CW+COUNT_W-1:0]    count_wide;

    assign pos_ext    = IW'(pos_reg);
    assign count_ext  = IW'(count_reg);
    assign parent_idx = (pos_ext - IW'(1)) >> 1;
    assign left_idx   = {pos_ext[IW-2:0], 1'b0} + IW'(1);
    assign right_idx  = left_idx + IW'(1);

    always_comb begin
        unique case (cmd.rd_sel)
            RD_PARENT: rd_addr_a = parent_idx[AW-1:0];
            RD_LAST:   rd_addr_a = count_reg[AW-1:0];
            default:   rd_addr_a = left_idx[AW-1:0];
        endcase
    end

    // on a tie the right child wins
    assign pick_left = (right_idx >= count_ext) || ahead(order_reg, rd_a_reg, rd_b_reg);
    assign pick_val  = pick_left ? rd_a_reg : rd_b_reg;
    assign pick_idx  = pick_left ? left_idx[AW-1:0] : right_idx[AW-1:0];

    assign wr_en = cmd.wr_cur | cmd.step_up | cmd.step_dn;
    always_comb begin
        priority if (cmd.step_up) begin
            wr_data = rd_a_reg;
        end else if (cmd.step_dn) begin
            wr_data = pick_val;
        end else begin
            wr_data = cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[pos_reg] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[right_idx[AW-1:0]];
    end

    assign sts.full       = (count_reg == CW'(HEAP_DEPTH));
    assign sts.empty      = (count_reg == '0);
    assign sts.count_zero = (count_reg == '0);
    assign sts.pos_zero   = (pos_reg == '0);
    assign sts.child_none = (left_idx >= count_ext);
    assign sts.up_move    = ahead(order_reg, cur_reg, rd_a_reg);
    assign sts.dn_move    = ahead(order_reg, pick_val, cur_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            if (cfg_we) begin
                order_reg <= cfg_wdata;
            end
            if (cmd.ins_start) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.del_start) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ins_start) begin
            cur_reg <= s_value;
            pos_reg <= count_reg[AW-1:0];
        end else if (cmd.load_cur) begin
            cur_reg <= rd_a_reg;
            pos_reg <= '0;
        end else if (cmd.step_up) begin
            pos_reg <= parent_idx[AW-1:0];
        end else if (cmd.step_dn) begin
            pos_reg <= pick_idx;
        end
        // the root is mirrored so it never costs a read
        if (wr_en && pos_reg == '0) begin
            root_reg <= wr_data;
        end
        if (cmd.del_start) begin
            removed_reg <= root_reg;
        end else if (cmd.ins_start || cmd.rej_full || cmd.rej_empty) begin
            removed_reg <= '0;
        end
        if (cmd.ins_start || cmd.del_start) begin
            status_reg <= ST_DONE;
        end else if (cmd.rej_full) begin
            status_reg <= ST_FULL;
        end else if (cmd.rej_empty) begin
            status_reg <= ST_EMPTY;
        end
    end

    assign count_wide = {{COUNT_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_removed    <= removed_reg;
            out_root       <= (count_reg != '0) ? root_reg : '0;
            out_root_valid <= (count_reg != '0);
            out_count      <= count_wide[COUNT_W-1:0];
            out_status     <= status_reg;
        end
    end

endmodule
`default_nettype wire
